// ----- sv/ptb_pkg.sv -----
package ptb_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int EV_CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_ALLOC      = 3'd1,
        KIND_SET_PERIOD = 3'd2,
        KIND_TEST_CLEAR = 3'd3,
        KIND_READ_TIME  = 3'd4
    } t_in_kind;

    typedef enum logic [1:0] {
        RES_FIRE  = 2'd0,
        RES_ALLOC = 2'd1,
        RES_FLAG  = 2'd2,
        RES_TIME  = 2'd3
    } t_res_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK_WALK,
        S_TICK_END,
        S_ALLOC,
        S_SET,
        S_TC_READ,
        S_TC_DONE,
        S_TIME
    } t_state;

    typedef struct packed {
        logic [15:0] period;
        logic [15:0] count_down;
        logic [7:0]  expiry;
    } t_entry;

    typedef struct packed {
        logic load;
        logic walk_en;
        logic tick_end;
        logic alloc_step;
        logic set_write;
        logic tc_read;
        logic tc_done;
        logic time_push;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic walk_done;
        logic pend_vld;
        logic scan_free;
        logic scan_zero;
    } t_dp_status;

endpackage

// ----- sv/ptb_ram.sv -----
module ptb_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ptb_ctrl.sv -----
module ptb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [2:0]         i_kind,
    output logic               o_ready,
    input  ptb_pkg::t_dp_status i_status,
    output ptb_pkg::t_dp_cmd    o_cmd
);

    ptb_pkg::t_state r_state;
    ptb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ptb_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (ptb_pkg::t_in_kind'(i_kind))
                        ptb_pkg::KIND_TICK:       n_state = ptb_pkg::S_TICK_WALK;
                        ptb_pkg::KIND_ALLOC:      n_state = ptb_pkg::S_ALLOC;
                        ptb_pkg::KIND_SET_PERIOD: n_state = ptb_pkg::S_SET;
                        ptb_pkg::KIND_TEST_CLEAR: n_state = ptb_pkg::S_TC_READ;
                        ptb_pkg::KIND_READ_TIME:  n_state = ptb_pkg::S_TIME;
                        default:                  n_state = ptb_pkg::S_IDLE;
                    endcase
                end
            end
            ptb_pkg::S_TICK_WALK: begin
                o_cmd.walk_en = 1'b1;
                if (i_status.walk_done) begin
                    n_state = ptb_pkg::S_TICK_END;
                end
            end
            ptb_pkg::S_TICK_END: begin
                if (!i_status.pend_vld || i_status.out_free) begin
                    o_cmd.tick_end = 1'b1;
                    n_state        = ptb_pkg::S_IDLE;
                end
            end
            ptb_pkg::S_ALLOC: begin
                if (i_status.scan_free || i_status.scan_zero) begin
                    if (i_status.out_free) begin
                        o_cmd.alloc_step = 1'b1;
                        n_state          = ptb_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.alloc_step = 1'b1;
                end
            end
            ptb_pkg::S_SET: begin
                o_cmd.set_write = 1'b1;
                n_state         = ptb_pkg::S_IDLE;
            end
            ptb_pkg::S_TC_READ: begin
                o_cmd.tc_read = 1'b1;
                n_state       = ptb_pkg::S_TC_DONE;
            end
            ptb_pkg::S_TC_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.tc_done = 1'b1;
                    n_state       = ptb_pkg::S_IDLE;
                end
            end
            ptb_pkg::S_TIME: begin
                if (i_status.out_free) begin
                    o_cmd.time_push = 1'b1;
                    n_state         = ptb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ptb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/ptb_datapath.sv -----
module ptb_datapath #(
    parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptb_pkg::t_dp_cmd     i_cmd,
    output ptb_pkg::t_dp_status  o_status,
    input  logic [2:0]          i_timer_index,
    input  logic [15:0]         i_period_ticks,
    input  logic                i_poll_mode,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [1:0]          o_result_kind,
    output logic [2:0]          o_slot,
    output logic [31:0]         o_value,
    output logic                o_full_res,
    output logic                o_last
);

    localparam int IDXW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNTW  = $clog2(NUM_TIMERS + 1);
    localparam int EXTW  = IDXW + 3;
    localparam int EVW   = ptb_pkg::EV_CNT_W;
    localparam int WORDW = $bits(ptb_pkg::t_entry);

    logic [2:0]             r_tidx,    n_tidx;
    logic [15:0]            r_period,  n_period;
    logic                   r_poll,    n_poll;
    logic [CNTW-1:0]        r_rd_idx,  n_rd_idx;
    logic                   r_st_vld,  n_st_vld;
    logic [IDXW-1:0]        r_st_idx,  n_st_idx;
    logic                   r_st_ok,   n_st_ok;
    logic                   r_pend_vld, n_pend_vld;
    logic [IDXW-1:0]        r_pend_idx, n_pend_idx;
    logic [EVW-1:0]         r_ev_cnt,  n_ev_cnt;
    logic [IDXW-1:0]        r_sc_idx,  n_sc_idx;
    logic [NUM_TIMERS-1:0]  r_in_use,  n_in_use;
    logic [NUM_TIMERS-1:0]  r_polled,  n_polled;
    logic [NUM_TIMERS-1:0]  r_valid,   n_valid;
    logic [31:0]            r_time,    n_time;
    logic                   r_out_vld, n_out_vld;
    ptb_pkg::t_res_kind      r_out_kind, n_out_kind;
    logic [2:0]             r_out_slot, n_out_slot;
    logic [31:0]            r_out_value, n_out_value;
    logic                   r_out_full, n_out_full;
    logic                   r_out_last, n_out_last;

    logic                   ram_we;
    logic [IDXW-1:0]        ram_waddr;
    logic [WORDW-1:0]       ram_wdata;
    logic                   ram_re;
    logic [IDXW-1:0]        ram_raddr;
    logic [WORDW-1:0]       ram_rdata;

    ptb_pkg::t_entry         ent;
    ptb_pkg::t_entry         upd;
    ptb_pkg::t_entry         fresh;
    logic                   out_free;
    logic                   rd_more;
    logic                   fire;
    logic                   emit;
    logic                   stall;
    logic                   advance;
    logic                   tidx_ok;
    logic [EXTW-1:0]        tidx_ext;
    logic [IDXW-1:0]        tidx_addr;
    logic [EXTW-1:0]        pend_ext;
    logic [EXTW-1:0]        sc_ext;

    ptb_ram #(
        .WIDTH (WORDW),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ent       = r_st_ok ? ptb_pkg::t_entry'(ram_rdata) : '0;
    assign out_free  = !r_out_vld || i_out_ready;
    assign rd_more   = r_rd_idx != CNTW'(NUM_TIMERS);
    assign tidx_ok   = int'(r_tidx) < NUM_TIMERS;
    assign tidx_ext  = EXTW'(r_tidx);
    assign tidx_addr = tidx_ext[IDXW-1:0];
    assign pend_ext  = EXTW'(r_pend_idx);
    assign sc_ext    = EXTW'(r_sc_idx);

    assign fresh.period     = r_period;
    assign fresh.count_down = r_period;
    assign fresh.expiry     = '0;

    always_comb begin
        upd = ent;
        if (ent.count_down == '0) begin
            upd.count_down = ent.period;
            if (ent.expiry != ptb_pkg::COUNT_MAX) begin
                upd.expiry = ent.expiry + 8'd1;
            end
        end else begin
            upd.count_down = ent.count_down - 16'd1;
        end
    end

    assign fire    = r_st_vld && (ent.count_down == '0) && r_in_use[r_st_idx]
                     && !r_polled[r_st_idx];
    assign emit    = fire && (r_ev_cnt != EVW'(ptb_pkg::MAX_RESULTS));
    assign stall   = emit && r_pend_vld && !out_free;
    assign advance = i_cmd.walk_en && !stall;

    assign o_status.out_free  = out_free;
    assign o_status.walk_done = !r_st_vld && !rd_more;
    assign o_status.pend_vld  = r_pend_vld;
    assign o_status.scan_free = !r_in_use[r_sc_idx];
    assign o_status.scan_zero = r_sc_idx == '0;

    always_comb begin
        n_tidx      = r_tidx;
        n_period    = r_period;
        n_poll      = r_poll;
        n_rd_idx    = r_rd_idx;
        n_st_vld    = r_st_vld;
        n_st_idx    = r_st_idx;
        n_st_ok     = r_st_ok;
        n_pend_vld  = r_pend_vld;
        n_pend_idx  = r_pend_idx;
        n_ev_cnt    = r_ev_cnt;
        n_sc_idx    = r_sc_idx;
        n_in_use    = r_in_use;
        n_polled    = r_polled;
        n_valid     = r_valid;
        n_time      = r_time;
        n_out_vld   = r_out_vld;
        n_out_kind  = r_out_kind;
        n_out_slot  = r_out_slot;
        n_out_value = r_out_value;
        n_out_full  = r_out_full;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_waddr   = r_st_idx;
        ram_wdata   = upd;
        ram_re      = 1'b0;
        ram_raddr   = r_rd_idx[IDXW-1:0];

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        if (i_cmd.load) begin
            n_tidx     = i_timer_index;
            n_period   = i_period_ticks;
            n_poll     = i_poll_mode;
            n_rd_idx   = '0;
            n_st_vld   = 1'b0;
            n_pend_vld = 1'b0;
            n_ev_cnt   = '0;
            n_sc_idx   = IDXW'(NUM_TIMERS - 1);
        end

        if (advance) begin
            if (r_st_vld) begin
                ram_we             = 1'b1;
                ram_waddr          = r_st_idx;
                ram_wdata          = upd;
                n_valid[r_st_idx]  = 1'b1;
                if (emit) begin
                    if (r_pend_vld) begin
                        n_out_vld   = 1'b1;
                        n_out_kind  = ptb_pkg::RES_FIRE;
                        n_out_slot  = pend_ext[2:0];
                        n_out_value = '0;
                        n_out_full  = 1'b0;
                        n_out_last  = 1'b0;
                    end
                    n_pend_vld = 1'b1;
                    n_pend_idx = r_st_idx;
                    n_ev_cnt   = r_ev_cnt + EVW'(1);
                end
            end
            if (rd_more) begin
                ram_re    = 1'b1;
                ram_raddr = r_rd_idx[IDXW-1:0];
                n_st_vld  = 1'b1;
                n_st_idx  = r_rd_idx[IDXW-1:0];
                n_st_ok   = r_valid[r_rd_idx[IDXW-1:0]];
                n_rd_idx  = r_rd_idx + CNTW'(1);
            end else begin
                n_st_vld = 1'b0;
            end
        end

        if (i_cmd.tick_end) begin
            if (r_pend_vld) begin
                n_out_vld   = 1'b1;
                n_out_kind  = ptb_pkg::RES_FIRE;
                n_out_slot  = pend_ext[2:0];
                n_out_value = '0;
                n_out_full  = 1'b0;
                n_out_last  = 1'b1;
            end
            n_pend_vld = 1'b0;
            n_time     = r_time + 32'd1;
        end

        if (i_cmd.alloc_step) begin
            if (!r_in_use[r_sc_idx]) begin
                ram_we             = 1'b1;
                ram_waddr          = r_sc_idx;
                ram_wdata          = fresh;
                n_valid[r_sc_idx]  = 1'b1;
                n_in_use[r_sc_idx] = 1'b1;
                n_polled[r_sc_idx] = r_poll;
                n_out_vld          = 1'b1;
                n_out_kind         = ptb_pkg::RES_ALLOC;
                n_out_slot         = sc_ext[2:0];
                n_out_value        = '0;
                n_out_full         = 1'b0;
                n_out_last         = 1'b1;
            end else if (r_sc_idx == '0) begin
                n_out_vld   = 1'b1;
                n_out_kind  = ptb_pkg::RES_ALLOC;
                n_out_slot  = '0;
                n_out_value = '0;
                n_out_full  = 1'b1;
                n_out_last  = 1'b1;
            end else begin
                n_sc_idx = r_sc_idx - IDXW'(1);
            end
        end

        if (i_cmd.set_write && tidx_ok) begin
            ram_we             = 1'b1;
            ram_waddr          = tidx_addr;
            ram_wdata          = fresh;
            n_valid[tidx_addr] = 1'b1;
        end

        if (i_cmd.tc_read) begin
            ram_re    = 1'b1;
            ram_raddr = tidx_addr;
            n_st_ok   = tidx_ok ? r_valid[tidx_addr] : 1'b0;
        end

        if (i_cmd.tc_done) begin
            if (tidx_ok) begin
                ram_we             = 1'b1;
                ram_waddr          = tidx_addr;
                ram_wdata          = {ent.period, ent.count_down, 8'd0};
                n_valid[tidx_addr] = 1'b1;
            end
            n_out_vld   = 1'b1;
            n_out_kind  = ptb_pkg::RES_FLAG;
            n_out_slot  = r_tidx;
            n_out_value = 32'(ent.expiry);
            n_out_full  = 1'b0;
            n_out_last  = 1'b1;
        end

        if (i_cmd.time_push) begin
            n_out_vld   = 1'b1;
            n_out_kind  = ptb_pkg::RES_TIME;
            n_out_slot  = '0;
            n_out_value = r_time;
            n_out_full  = 1'b0;
            n_out_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx   <= '0;
            r_st_vld   <= 1'b0;
            r_st_ok    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_ev_cnt   <= '0;
            r_sc_idx   <= '0;
            r_in_use   <= '0;
            r_polled   <= '0;
            r_valid    <= '0;
            r_time     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_idx   <= n_rd_idx;
            r_st_vld   <= n_st_vld;
            r_st_ok    <= n_st_ok;
            r_pend_vld <= n_pend_vld;
            r_ev_cnt   <= n_ev_cnt;
            r_sc_idx   <= n_sc_idx;
            r_in_use   <= n_in_use;
            r_polled   <= n_polled;
            r_valid    <= n_valid;
            r_time     <= n_time;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tidx      <= n_tidx;
        r_period    <= n_period;
        r_poll      <= n_poll;
        r_st_idx    <= n_st_idx;
        r_pend_idx  <= n_pend_idx;
        r_out_kind  <= n_out_kind;
        r_out_slot  <= n_out_slot;
        r_out_value <= n_out_value;
        r_out_full  <= n_out_full;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid   = r_out_vld;
    assign o_result_kind = r_out_kind;
    assign o_slot        = r_out_slot;
    assign o_value       = r_out_value;
    assign o_full_res    = r_out_full;
    assign o_last        = r_out_last;

endmodule

// ----- sv/periodic_timer_bank_top.sv -----
// Bank of periodic timers with a wrapping 32-bit tick counter.
// Commands arrive on the s_axis channel, one per transfer; tuser carries the
// command kind (tick, allocate, set period, test and clear, read time) and
// tdata the timer index, the period and the polling flag.
// Results leave on the m_axis channel; tuser carries the result kind and
// tlast marks the final result that a command produces.
// A tick walks every timer through the entry memory, one timer per cycle unless
// a fire result waits on a full output register, with the read of the next entry
// overlapped with the write-back of the current one. Allocation scans the in-use
// flags from the top slot down, one slot per cycle. Test and clear reads the
// entry first and then writes it back with its expiry count cleared. The next
// command is taken once the current one has finished.
// Results sit in a single output register, so a new command can be accepted
// while the last result still waits; when the receiver stalls, the walk or
// the command holds until that register drains, and no result is dropped.
// Reset clears all timers, flags and the tick counter at once; the entry
// memory is masked by per-entry valid bits, so no clearing pass is needed.
module periodic_timer_bank_top #(
    parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // timer_index, period_ticks, poll_mode, zero fill
    input  logic [2:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // slot, value, full_res, zero fill
    output logic [1:0]  m_axis_tuser,  // result_kind
    output logic        m_axis_tlast
);

    ptb_pkg::t_dp_cmd    cmd;
    ptb_pkg::t_dp_status status;
    logic [2:0]         slot;
    logic [31:0]        value;
    logic               full_res;

    ptb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_kind   (s_axis_tuser),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ptb_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_timer_index  (s_axis_tdata[2:0]),
        .i_period_ticks (s_axis_tdata[18:3]),
        .i_poll_mode    (s_axis_tdata[19]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_result_kind  (m_axis_tuser),
        .o_slot         (slot),
        .o_value        (value),
        .o_full_res     (full_res),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, full_res, value, slot};

endmodule

// ----- dv/periodic_timer_bank_top_test.sv -----
module periodic_timer_bank_top_test;

    localparam int NT          = ptb_pkg::NUM_TIMERS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;
    localparam int PHASE_ITEMS = 97;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  idx;
        logic [15:0] period;
        logic        poll;
    } t_cmd;

    typedef struct packed {
        ptb_pkg::t_res_kind kind;
        logic [2:0]  slot;
        logic [31:0] value;
        logic        full;
        logic        last;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // timer_index, period_ticks, poll_mode, zero fill
    logic [2:0]  s_axis_tuser = '0;  // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // slot, value, full_res, zero fill
    logic [1:0]  m_axis_tuser;       // result_kind
    logic        m_axis_tlast;

    t_cmd pending_cmds[$];
    t_res expected_results[$];

    logic [15:0] tmr_period [NT];
    logic [15:0] tmr_count  [NT];
    logic [7:0]  tmr_expiry [NT];
    logic        tmr_polled [NT];
    logic        tmr_used   [NT];
    logic [31:0] tick_count;

    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    bit   rx_hold = 1'b0;
    bit   in_taken = 1'b0;
    int   mismatches = 0;
    int   quiet_cycles = 0;
    t_cmd drv_cmd;

    periodic_timer_bank_top #(
        .NUM_TIMERS(NT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < NT; i++) begin
            tmr_period[i] = '0;
            tmr_count[i]  = '0;
            tmr_expiry[i] = '0;
            tmr_polled[i] = 1'b0;
            tmr_used[i]   = 1'b0;
        end
        tick_count = '0;
    end

    function automatic t_cmd make_cmd(logic [2:0] kind, logic [2:0] idx,
                                      logic [15:0] period, logic poll);
        t_cmd c;
        c.kind   = kind;
        c.idx    = idx;
        c.period = period;
        c.poll   = poll;
        return c;
    endfunction

    function automatic t_cmd random_cmd(bit allow_top);
        t_cmd c;
        int   roll;
        roll     = $urandom_range(99);
        c.idx    = allow_top ? 3'($urandom_range(NT - 1)) : 3'($urandom_range(NT - 2));
        c.period = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
        c.poll   = 1'($urandom);
        if (roll < 70) begin
            c.kind = ptb_pkg::KIND_TICK;
        end else if (roll < 75) begin
            c.kind = ptb_pkg::KIND_ALLOC;
        end else if (roll < 83) begin
            c.kind = ptb_pkg::KIND_SET_PERIOD;
        end else if (roll < 92) begin
            c.kind = ptb_pkg::KIND_TEST_CLEAR;
        end else if (roll < 97) begin
            c.kind = ptb_pkg::KIND_READ_TIME;
        end else begin
            c.kind = 3'(ptb_pkg::KIND_READ_TIME) + 3'($urandom_range(1, 3));
        end
        return c;
    endfunction

    task automatic note_mismatch(string msg);
        if (mismatches < 100) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // Advances the timer bank by one command and queues the results it produces.
    task automatic step_timers(t_cmd c);
        t_res fires[$];
        t_res r;
        bit   free_seen;
        int   pick;
        r = '0;
        case (c.kind)
            ptb_pkg::KIND_TICK: begin
                for (int i = 0; i < NT; i++) begin
                    if (tmr_count[i] != 0) begin
                        tmr_count[i] = tmr_count[i] - 1'b1;
                    end else begin
                        tmr_count[i] = tmr_period[i];
                        if (tmr_expiry[i] != ptb_pkg::COUNT_MAX) begin
                            tmr_expiry[i] = tmr_expiry[i] + 1'b1;
                        end
                        if (tmr_used[i] && !tmr_polled[i]
                                && fires.size() < ptb_pkg::MAX_RESULTS) begin
                            r.kind = ptb_pkg::RES_FIRE;
                            r.slot = 3'(i);
                            fires.push_back(r);
                        end
                    end
                end
                tick_count = tick_count + 1'b1;
                if (fires.size() > 0) fires[fires.size() - 1].last = 1'b1;
                foreach (fires[k]) expected_results.push_back(fires[k]);
            end
            ptb_pkg::KIND_ALLOC: begin
                free_seen = 1'b0;
                pick = 0;
                for (int i = 0; i < NT; i++) begin
                    if (!tmr_used[i]) begin
                        pick = i;
                        free_seen = 1'b1;
                    end
                end
                r.kind = ptb_pkg::RES_ALLOC;
                r.last = 1'b1;
                if (free_seen) begin
                    tmr_used[pick]   = 1'b1;
                    tmr_period[pick] = c.period;
                    tmr_count[pick]  = c.period;
                    tmr_expiry[pick] = '0;
                    tmr_polled[pick] = c.poll;
                    r.slot = 3'(pick);
                end else begin
                    r.full = 1'b1;
                end
                expected_results.push_back(r);
            end
            ptb_pkg::KIND_SET_PERIOD: begin
                if (c.idx < NT) begin
                    tmr_period[c.idx] = c.period;
                    tmr_count[c.idx]  = c.period;
                    tmr_expiry[c.idx] = '0;
                end
            end
            ptb_pkg::KIND_TEST_CLEAR: begin
                r.kind = ptb_pkg::RES_FLAG;
                r.slot = c.idx;
                r.last = 1'b1;
                if (c.idx < NT) begin
                    r.value = 32'(tmr_expiry[c.idx]);
                    tmr_expiry[c.idx] = '0;
                end
                expected_results.push_back(r);
            end
            ptb_pkg::KIND_READ_TIME: begin
                r.kind  = ptb_pkg::RES_TIME;
                r.value = tick_count;
                r.last  = 1'b1;
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_res got;
        t_res want;
        got.kind  = ptb_pkg::t_res_kind'(m_axis_tuser);
        got.slot  = m_axis_tdata[2:0];
        got.value = m_axis_tdata[34:3];
        got.full  = m_axis_tdata[35];
        got.last  = m_axis_tlast;
        if (expected_results.size() == 0) begin
            note_mismatch($sformatf("unexpected result kind %0d slot %0d value %0d",
                                    got.kind, got.slot, got.value));
        end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind)
                note_mismatch($sformatf("result_kind %0d, expected %0d", got.kind, want.kind));
            if (got.slot !== want.slot)
                note_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
            if (got.value !== want.value)
                note_mismatch($sformatf("value %0d, expected %0d", got.value, want.value));
            if (got.full !== want.full)
                note_mismatch($sformatf("full_res %0b, expected %0b", got.full, want.full));
            if (got.last !== want.last)
                note_mismatch($sformatf("tlast %0b, expected %0b", got.last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        in_taken = s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) check_result();
            if (in_taken) begin
                step_timers(make_cmd(s_axis_tuser, s_axis_tdata[2:0],
                                     s_axis_tdata[18:3], s_axis_tdata[19]));
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || in_taken) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    drv_cmd = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0, drv_cmd.poll, drv_cmd.period, drv_cmd.idx};
                    s_axis_tuser  <= drv_cmd.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles == STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // The receiver holds off early on so that the output register fills and the
    // block has to stall its input while the sender keeps offering commands.
    initial begin
        @(posedge i_rst_n);
        repeat (4) @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        int tx_pct[4];
        int rx_pct[4];
        tx_pct = '{0, 72, 0, 31};
        rx_pct = '{0, 0, 72, 31};

        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_READ_TIME, 3'd0, 16'h0000, 1'b0));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_TICK, 3'd0, 16'h0000, 1'b0));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_TEST_CLEAR, 3'd0, 16'h0000, 1'b0));
        // The top slot is taken first, polled with period zero, so its count saturates.
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_ALLOC, 3'd0, 16'h0000, 1'b1));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_ALLOC, 3'd7, 16'hFFFF, 1'b0));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_ALLOC, 3'd0, 16'h0000, 1'b0));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_ALLOC, 3'd0, 16'h0001, 1'b0));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_ALLOC, 3'd0, 16'h0002, 1'b0));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_ALLOC, 3'd0, 16'h8000, 1'b1));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_ALLOC, 3'd0, 16'h5555, 1'b0));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_ALLOC, 3'd0, 16'hAAAA, 1'b0));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_ALLOC, 3'd0, 16'h1234, 1'b0));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_TICK, 3'd0, 16'h0000, 1'b0));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_SET_PERIOD, 3'd0, 16'h0000, 1'b0));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_SET_PERIOD, 3'd6, 16'hFFFF, 1'b1));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_TICK, 3'd0, 16'h0000, 1'b0));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_TEST_CLEAR, 3'd5, 16'h0000, 1'b0));
        for (int k = 1; k <= 3; k++) begin
            pending_cmds.push_back(make_cmd(3'(ptb_pkg::KIND_READ_TIME) + 3'(k), 3'(k),
                                            16'($urandom), 1'($urandom)));
        end
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_READ_TIME, 3'd0, 16'h0000, 1'b0));
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_TICK, 3'd0, 16'h0000, 1'b0));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            while (pending_cmds.size() != 0 || s_axis_tvalid) @(posedge i_clk);
            tx_idle_pct  = tx_pct[ph];
            rx_stall_pct = rx_pct[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) pending_cmds.push_back(random_cmd(1'b0));
        end
        pending_cmds.push_back(make_cmd(ptb_pkg::KIND_TEST_CLEAR, 3'd7, 16'h0000, 1'b0));
        for (int n = 0; n < 40; n++) pending_cmds.push_back(random_cmd(1'b1));

        while (pending_cmds.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
